/* sv/exhaustive_word_enumerator_unit_macros.svh */
// Assertion macros for the word enumerator RTL.
`ifndef EXHAUSTIVE_WORD_ENUMERATOR_UNIT_MACROS_SVH
`define EXHAUSTIVE_WORD_ENUMERATOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every clock edge outside reset.
`define EWE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Check that a condition never holds outside reset.
`define EWE_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define EWE_ASSERT(lbl, clk, rst, prop)
`define EWE_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* sv/ewe_pkg.sv */
package ewe_pkg;

   // Sizes of the odometer and the alphabet store
   localparam int MAX_WORD_LENGTH = 32;
   localparam int ALPHABET_DEPTH  = 255;

   // Field widths
   localparam int DIGIT_W      = 8;
   localparam int CHAR_W       = 8;
   localparam int INDEX_W      = 8;
   localparam int SIZE_W       = 8;
   localparam int WLEN_W       = 6;
   localparam int CSR_DATA_W   = 8;
   localparam int CSR_INDEX_W  = 1;

   // Derived widths
   localparam int STEP_W = (MAX_WORD_LENGTH > 1) ? $clog2(MAX_WORD_LENGTH) : 1;
   localparam int LEN_W  = $clog2(MAX_WORD_LENGTH + 1);
   localparam int ADDR_W = $clog2(ALPHABET_DEPTH);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHABET_SIZE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_LENGTH   = 1'b1;

   // Reset values of the registers
   localparam logic [SIZE_W-1:0] ALPHABET_SIZE_RESET = 8'd10;
   localparam logic [WLEN_W-1:0] WORD_LENGTH_RESET   = 6'd8;

   // Operation codes
   localparam logic OP_WRITE    = 1'b0;
   localparam logic OP_GENERATE = 1'b1;

   // Terminator character
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

   // Control from the sequencer to the digit chain
   typedef struct packed {
      logic shift;
      logic bump;
   } chain_ctrl_type;

endpackage

/* sv/ewe_digit_cell.sv */
module ewe_digit_cell import ewe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  logic [DIGIT_W-1:0] digit_in,
   output logic [DIGIT_W-1:0] digit_out
);

   logic [DIGIT_W-1:0] digit_ff;

   // Take the neighbor's digit on every shift
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else if (shift) begin
         digit_ff <= digit_in;
      end
   end

   assign digit_out = digit_ff;

endmodule

/* sv/ewe_digit_chain.sv */
module ewe_digit_chain import ewe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  chain_ctrl_type     ctrl,
   input  logic [SIZE_W-1:0]  alphabet_size,
   output logic [DIGIT_W-1:0] head_digit,
   output logic               wrap
);

   logic [DIGIT_W-1:0] digit [MAX_WORD_LENGTH];
   logic [DIGIT_W-1:0] next_head;
   logic [SIZE_W-1:0]  radix;

   // Treat a zero radix as one
   assign radix = (alphabet_size == '0) ? SIZE_W'(1) : alphabet_size;

   // Increment the head digit, wrap at the radix
   assign head_digit = digit[0];
   assign wrap = ({1'b0, head_digit} + (DIGIT_W+1)'(1)) >= (DIGIT_W+1)'(radix);

   always_comb begin
      if (!ctrl.bump) begin
         next_head = head_digit;
      end else if (wrap) begin
         next_head = '0;
      end else begin
         next_head = head_digit + DIGIT_W'(1);
      end
   end

   // Ring of cells: each takes its upper neighbor, the tail takes the updated head
   for (genvar i = 0; i < MAX_WORD_LENGTH; i++) begin : g_cell
      logic [DIGIT_W-1:0] cell_in;
      if (i == MAX_WORD_LENGTH - 1) begin : g_tail
         assign cell_in = next_head;
      end else begin : g_body
         assign cell_in = digit[i+1];
      end
      ewe_digit_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (ctrl.shift),
         .digit_in  (cell_in),
         .digit_out (digit[i])
      );
   end

endmodule

/* sv/exhaustive_word_enumerator_unit.sv */
// The first result of a generate transaction is registered in the output register once the
// sequencer is in the run state and the output slot is free. A generate transaction walks one
// full turn of the 32-cell digit ring plus the newline, or gives one exhausted response.
// Reset: synchronous, active high; clears the odometer, the exhausted flag, the sequencer
// and the registers (alphabet size 10, word length 8). The alphabet store is not cleared.
`include "exhaustive_word_enumerator_unit_macros.svh"
module exhaustive_word_enumerator_unit import ewe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [INDEX_W-1:0]     req_entry_index,
   input  logic [CHAR_W-1:0]      req_symbol,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_W-1:0]      rsp_character,
   output logic                   rsp_last,
   output logic                   rsp_exhausted,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_NL, ST_EXH} state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               carry_ff, carry_in;
   logic               done_ff, done_in;
   logic [SIZE_W-1:0]  alphabet_size_ff;
   logic [WLEN_W-1:0]  word_length_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_character_ff;
   logic               rsp_last_ff;
   logic               rsp_exhausted_ff;
   logic [CHAR_W-1:0]  alphabet_mem [ALPHABET_DEPTH];

   logic               req_fire;
   logic               slot_free;
   logic               in_len;
   logic               emit_char;
   logic               emit_nl;
   logic               emit_exh;
   logic [LEN_W-1:0]   len;
   logic [DIGIT_W-1:0] head_digit;
   logic               wrap;
   chain_ctrl_type     chain_ctrl;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Clamp the word length to the ring size
   assign len = (32'(word_length_ff) > MAX_WORD_LENGTH) ? LEN_W'(MAX_WORD_LENGTH)
                                                         : LEN_W'(word_length_ff);
   assign in_len = LEN_W'(step_ff) < len;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_size_ff <= ALPHABET_SIZE_RESET;
         word_length_ff   <= WORD_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ALPHABET_SIZE: alphabet_size_ff <= csr_write_data;
            CSR_WORD_LENGTH:   word_length_ff   <= csr_write_data[WLEN_W-1:0];
            default:           ;
         endcase
      end
   end

   // Alphabet store write port
   always_ff @(posedge clock) begin
      if (req_fire && req_op == OP_WRITE && 32'(req_entry_index) < ALPHABET_DEPTH) begin
         alphabet_mem[req_entry_index[ADDR_W-1:0]] <= req_symbol;
      end
   end

   // Sequencer next state
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      carry_in   = carry_ff;
      done_in    = done_ff;
      emit_char  = 1'b0;
      emit_nl    = 1'b0;
      emit_exh   = 1'b0;
      chain_ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_op == OP_GENERATE) begin
               if (done_ff) begin
                  state_in = ST_EXH;
               end else begin
                  state_in = ST_RUN;
                  step_in  = '0;
                  carry_in = 1'b1;
               end
            end
         end
         ST_RUN: begin
            // Rotate freely past unused digits, wait for the output slot on used ones
            chain_ctrl.shift = !in_len || slot_free;
            chain_ctrl.bump  = in_len && carry_ff;
            emit_char        = in_len && slot_free;
            if (chain_ctrl.shift) begin
               if (chain_ctrl.bump) begin
                  carry_in = wrap;
               end
               if (step_ff == STEP_W'(MAX_WORD_LENGTH - 1)) begin
                  state_in = ST_NL;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         ST_NL: begin
            if (slot_free) begin
               emit_nl  = 1'b1;
               done_in  = carry_ff;
               state_in = ST_IDLE;
            end
         end
         ST_EXH: begin
            if (slot_free) begin
               emit_exh = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (emit_char || emit_nl || emit_exh) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold state and the output register; read the alphabet into it
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         carry_ff     <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         carry_ff     <= carry_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      priority if (emit_char) begin
         rsp_character_ff <= (32'(head_digit) < ALPHABET_DEPTH)
                             ? alphabet_mem[head_digit[ADDR_W-1:0]] : '0;
         rsp_last_ff      <= 1'b0;
         rsp_exhausted_ff <= 1'b0;
      end else if (emit_nl) begin
         rsp_character_ff <= NEWLINE_CHAR;
         rsp_last_ff      <= 1'b1;
         rsp_exhausted_ff <= 1'b0;
      end else if (emit_exh) begin
         rsp_character_ff <= '0;
         rsp_last_ff      <= 1'b1;
         rsp_exhausted_ff <= 1'b1;
      end else begin
         rsp_character_ff <= rsp_character_ff;
      end
   end

   ewe_digit_chain u_chain (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (chain_ctrl),
      .alphabet_size (alphabet_size_ff),
      .head_digit    (head_digit),
      .wrap          (wrap)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_exhausted = rsp_exhausted_ff;

   // Checks
   `EWE_ASSERT(exh_is_last, clock, reset, rsp_valid && rsp_exhausted |-> rsp_last && rsp_character == '0)
   `EWE_ASSERT(nl_char, clock, reset, rsp_valid && rsp_last && !rsp_exhausted |-> rsp_character == NEWLINE_CHAR)
   `EWE_ASSERT_NEVER(done_sticky, clock, reset, !$past(reset) && $fell(done_ff))
   `EWE_ASSERT(nl_after_turn, clock, reset, state_ff == ST_NL && $past(state_ff) == ST_RUN && !$past(reset) |-> $past(step_ff) == STEP_W'(MAX_WORD_LENGTH - 1))

endmodule
